/* rtl/mcd_pkg.sv */
// Shared types, constants and helper functions for the multi-channel clock divider.
// No dependencies; used by mcd_cell and multi_channel_clock_divider.
package mcd_pkg;

  // Channel bank size and field widths
  localparam int Channels = 6;
  localparam int ChanW    = 3;
  localparam int FuncW    = 3;
  localparam int ValW     = 8;
  localparam int RatioW   = 6;
  localparam int CountW   = 5;
  localparam int LevelsW  = 6;

  // Operation codes
  localparam logic [FuncW-1:0] FuncTick   = 3'd0;
  localparam logic [FuncW-1:0] FuncClear  = 3'd1;
  localparam logic [FuncW-1:0] FuncGet    = 3'd2;
  localparam logic [FuncW-1:0] FuncSet    = 3'd3;
  localparam logic [FuncW-1:0] FuncRotate = 3'd4;
  localparam logic [FuncW-1:0] FuncSwap   = 3'd5;
  // Spare code, driven into the row on idle cycles: no state change
  localparam logic [FuncW-1:0] FuncNop    = 3'd7;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ValW-1:0]  set_value;
  } cell_cmd_t;

  // Quantise a raw 8-bit control value into a division ratio (steps of 32)
  function automatic logic [RatioW-1:0] quantize_ratio(input logic [ValW-1:0] v);
    logic [RatioW-1:0] r;
    case (v[7:5])
      3'd0:    r = 6'd1;
      3'd1:    r = 6'd2;
      3'd2:    r = 6'd3;
      3'd3:    r = 6'd4;
      3'd4:    r = 6'd8;
      3'd5:    r = 6'd12;
      3'd6:    r = 6'd16;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

  // Reset ratio of a channel: powers of two, the sixth and anything past it at 32
  function automatic logic [RatioW-1:0] init_ratio(input int idx);
    logic [RatioW-1:0] r;
    case (idx)
      0:       r = 6'd1;
      1:       r = 6'd2;
      2:       r = 6'd4;
      3:       r = 6'd8;
      4:       r = 6'd16;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

endpackage

/* rtl/mcd_cell.sv */
// One divider channel: tick counter, output level and division ratio.
// Depends on mcd_pkg. Ratio is handed to/from neighbours for rotate and swap.
module mcd_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mcd_pkg::cell_cmd_t        cmd_i,
  input  logic                      sel_i,
  input  logic [mcd_pkg::RatioW-1:0] ratio_init_i,
  input  logic [mcd_pkg::RatioW-1:0] rot_ratio_i,
  input  logic [mcd_pkg::RatioW-1:0] swap_ratio_i,
  output logic [mcd_pkg::RatioW-1:0] ratio_o,
  output logic                      level_d_o
);
  import mcd_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic              level_q, level_d;
  logic [RatioW-1:0] ratio_q, ratio_d;
  logic [RatioW-1:0] count_inc;

  // Counter widened by one bit so that a ratio of 32 divides correctly
  assign count_inc = {1'b0, count_q} + RatioW'(1);

  // Next-state logic for this channel
  always_comb begin
    count_d = count_q;
    level_d = level_q;
    ratio_d = ratio_q;
    case (cmd_i.func)
      FuncTick: begin
        if (sel_i) begin
          if (count_inc >= ratio_q) begin
            count_d = '0;
            level_d = ~level_q;
          end else begin
            count_d = count_inc[CountW-1:0];
          end
        end
      end
      FuncClear: begin
        if (sel_i) begin
          count_d = '0;
          level_d = 1'b0;
        end
      end
      FuncSet: begin
        if (sel_i) begin
          ratio_d = quantize_ratio(cmd_i.set_value);
        end
      end
      FuncRotate: ratio_d = rot_ratio_i;
      FuncSwap:   ratio_d = swap_ratio_i;
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
      ratio_q <= ratio_init_i;
    end else begin
      count_q <= count_d;
      level_q <= level_d;
      ratio_q <= ratio_d;
    end
  end

  assign ratio_o   = ratio_q;
  assign level_d_o = level_d;

endmodule

/* rtl/multi_channel_clock_divider.sv */
// Multi-channel clock divider: a row of mcd_cell channels sharing one command.
// The result strobe is registered and rises in the cycle after acceptance.
// Throughput: one transaction per cycle; busy stays low, and every cell registers its update.
// Reset: asynchronous, active low; counters and levels clear, ratios go to 1,2,4,8,16,32.
// The result strobe is high for a single cycle; the receiver cannot stall it.
// Depends on mcd_pkg and mcd_cell.
module multi_channel_clock_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [mcd_pkg::FuncW-1:0]  func_i,
  input  logic [mcd_pkg::ChanW-1:0]  channel_i,
  input  logic [mcd_pkg::ValW-1:0]   set_value_i,
  output logic                       result_valid_o,
  output logic                       addressed_level_o,
  output logic [mcd_pkg::LevelsW-1:0] all_levels_o
);
  import mcd_pkg::*;

  localparam int Half = Channels / 2;

  cell_cmd_t         cmd;
  logic              accept;
  logic              chan_ok;
  logic [RatioW-1:0] ratio  [Channels];
  logic [RatioW-1:0] swap_r [Channels];
  logic [Channels-1:0] lvl_d;
  logic [Channels-1:0] sel;
  logic              addr_lvl_d;
  logic [LevelsW-1:0] levels_d;

  logic              result_valid_q;
  logic              addr_lvl_q;
  logic [LevelsW-1:0] levels_q;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign chan_ok = 32'(channel_i) < Channels;

  // Idle cycles look like an unused code, so nothing moves
  assign cmd.func      = accept ? func_i : FuncNop;
  assign cmd.set_value = set_value_i;

  // Row of cells; rotate takes the left neighbour, swap the partner half
  for (genvar i = 0; i < Channels; i++) begin : g_cell
    assign sel[i] = accept && (32'(channel_i) == i);

    if (i < Half) begin : g_lo
      assign swap_r[i] = ratio[i + Half];
    end else if (i < 2 * Half) begin : g_hi
      assign swap_r[i] = ratio[i - Half];
    end else begin : g_keep
      assign swap_r[i] = ratio[i];
    end

    mcd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .sel_i        (sel[i]),
      .ratio_init_i (init_ratio(i)),
      .rot_ratio_i  (ratio[(i + Channels - 1) % Channels]),
      .swap_ratio_i (swap_r[i]),
      .ratio_o      (ratio[i]),
      .level_d_o    (lvl_d[i])
    );
  end

  // Addressed level after the operation; 0 when out of range
  always_comb begin
    addr_lvl_d = 1'b0;
    for (int i = 0; i < Channels; i++) begin
      if (32'(channel_i) == i) begin
        addr_lvl_d = lvl_d[i];
      end
    end
    if (!chan_ok) begin
      addr_lvl_d = 1'b0;
    end
  end

  // Level vector: one bit per channel, all six channels are reported
  for (genvar b = 0; b < LevelsW; b++) begin : g_lvl
    if (b < Channels) begin : g_on
      assign levels_d[b] = lvl_d[b];
    end else begin : g_off
      assign levels_d[b] = 1'b0;
    end
  end

  // Result register: one-cycle strobe per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_lvl_q <= addr_lvl_d;
      levels_q   <= levels_d;
    end
  end

  assign result_valid_o    = result_valid_q;
  assign addressed_level_o = addr_lvl_q;
  assign all_levels_o      = levels_q;

endmodule
